@@ src/mcs_pkg.sv @@
// Package for the measurement campaign sequencer: result kinds, request codes,
// register indexes, the campaign phase type and the result record.
// Has no dependencies; used by measurement_campaign_sequencer.
package mcs_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  // Widths of the configuration port.
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // Depth of the result queue and its pointer width.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  // Saturation value of the 24-bit tick counters.
  localparam logic [23:0] MAX24 = 24'hFF_FFFF;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_STARTED = 3'd1,
    KIND_BUSY    = 3'd2,
    KIND_GATE    = 3'd3,
    KIND_SAMPLE  = 3'd4,
    KIND_DONE    = 3'd5,
    KIND_ABORTED = 3'd6,
    KIND_TIMEOUT = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    REG_WAIT_DELAY    = 3'd0,
    REG_BURST_COUNT   = 3'd1,
    REG_BURST_GAP     = 3'd2,
    REG_TIME_LIMIT    = 3'd3,
    REG_RESTORE_EN    = 3'd4,
    REG_CHANNEL_COUNT = 3'd5,
    REG_CHANNEL_LIST  = 3'd6,
    REG_ACTUATOR_TAB  = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_WAIT   = 3'b010,
    PH_SAMPLE = 3'b100
  } phase_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  sample_channel;
    logic [31:0] sample_value;
    logic [23:0] sample_time;
    logic        drive_valid;
    logic [7:0]  drive_mask;
    logic [7:0]  drive_value;
    logic        running;
    logic        last;
  } res_t;

  // Result that ends a campaign, with the optional restore drive.
  function automatic res_t end_result(kind_t k, logic [23:0] t, logic restore,
                                      logic [7:0] m, logic [7:0] cap);
    res_t r;
    r                = '0;
    r.kind           = k;
    r.sample_time    = t;
    r.drive_valid    = restore;
    r.drive_mask     = restore ? m : 8'd0;
    r.drive_value    = restore ? (cap & m) : 8'd0;
    r.running        = 1'b0;
    return r;
  endfunction

  // Increment that holds at the top of the 24-bit range.
  function automatic logic [23:0] sat_inc24(logic [23:0] x);
    return (x == MAX24) ? x : x + 24'd1;
  endfunction

endpackage

@@ src/measurement_campaign_sequencer.sv @@
// Measurement campaign sequencer top level: input register, campaign logic,
// result queue and APB-style register file. Depends on mcs_pkg.
//
// The block takes one request per clock cycle while the result queue has room:
// a millisecond tick, a start or a user abort. A request is held in an input
// register, worked by a single pass of logic against the campaign state, and
// its results (none, one or two) go into a four-entry result queue that feeds
// the output channel and offers results from its head. The queue drains one
// result per cycle while the receiver is ready, so the sustained rate is one
// request per cycle except that a tick which yields both a sample and a done
// result adds a second result to drain; a request is worked only when the queue
// has room for two results. Configuration registers sit at byte address 8*i on a
// 64-bit port and are to be written only while no campaign request is in flight.
module measurement_campaign_sequencer #(
  parameter int unsigned MAX_CHANNELS  = 8,
  parameter int unsigned NUM_ACTUATORS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic                        in_gate_blocked,
  input  logic [7:0]                  in_switch_states,
  input  logic                        in_channel_found,
  input  logic [31:0]                 in_sample_word,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_sample_channel,
  output logic [31:0]                 out_sample_value,
  output logic [23:0]                 out_sample_time,
  output logic                        out_drive_valid,
  output logic [7:0]                  out_drive_mask,
  output logic [7:0]                  out_drive_value,
  output logic                        out_running,
  output logic                        out_last,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mcs_pkg::ADDR_W-1:0]  paddr,
  input  logic [mcs_pkg::DATA_W-1:0]  pwdata,
  output logic [mcs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Actuators beyond NUM_ACTUATORS are never driven.
  localparam logic [7:0] ACT_LIMIT = 8'((9'd1 << NUM_ACTUATORS) - 9'd1);
  localparam logic [3:0] MAX_CH    = 4'(MAX_CHANNELS);

  // Configuration registers
  logic [23:0] wait_delay_r;
  logic [7:0]  burst_count_r;
  logic [15:0] burst_gap_r;
  logic [23:0] time_limit_r;
  logic        restore_en_r;
  logic [3:0]  channel_count_r;
  logic [63:0] channel_list_r;
  logic [15:0] actuator_tab_r;

  logic                   cfg_wr;
  mcs_pkg::reg_idx_t      cfg_idx;

  // Input register
  logic        in_vld_r;
  logic [1:0]  func_r;
  logic        gate_r;
  logic [7:0]  switches_r;
  logic        found_r;
  logic [31:0] word_r;

  // Campaign state
  mcs_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] tss_r, tss_nxt;
  logic [23:0] tip_r, tip_nxt;
  logic [23:0] tsb_r, tsb_nxt;
  logic [7:0]  burst_r, burst_nxt;
  logic [3:0]  ch_r, ch_nxt;
  logic [7:0]  cap_r, cap_nxt;

  // Working signals of the single pass
  logic [23:0]     tss_inc, tip_inc, tsb_inc;
  logic [7:0]      burst_inc;
  logic [3:0]      ch_cnt, ch_step;
  logic [7:0]      act_mask;
  logic            is_nan;
  mcs_pkg::res_t   res0, res1;
  logic [1:0]      n_res;
  logic            proc;

  // Result queue
  mcs_pkg::res_t                  rq_r [mcs_pkg::RQ_DEPTH];
  logic [mcs_pkg::RQ_PTR_W-1:0]   rq_wr_r, rq_rd_r;
  logic [mcs_pkg::RQ_CNT_W-1:0]   rq_cnt_r;
  logic                           rq_pop;
  logic                           rq_room;
  mcs_pkg::res_t                  rq_head;

  // Register file: the write lands on the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = mcs_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_delay_r    <= 24'd0;
      burst_count_r   <= 8'd1;
      burst_gap_r     <= 16'd0;
      time_limit_r    <= 24'd60000;
      restore_en_r    <= 1'b1;
      channel_count_r <= 4'd1;
      channel_list_r  <= 64'd0;
      actuator_tab_r  <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mcs_pkg::REG_WAIT_DELAY:    wait_delay_r    <= pwdata[23:0];
        mcs_pkg::REG_BURST_COUNT:   burst_count_r   <= pwdata[7:0];
        mcs_pkg::REG_BURST_GAP:     burst_gap_r     <= pwdata[15:0];
        mcs_pkg::REG_TIME_LIMIT:    time_limit_r    <= pwdata[23:0];
        mcs_pkg::REG_RESTORE_EN:    restore_en_r    <= pwdata[0];
        mcs_pkg::REG_CHANNEL_COUNT: channel_count_r <= pwdata[3:0];
        mcs_pkg::REG_CHANNEL_LIST:  channel_list_r  <= pwdata;
        mcs_pkg::REG_ACTUATOR_TAB:  actuator_tab_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back of the registers.
  always_comb begin
    case (cfg_idx)
      mcs_pkg::REG_WAIT_DELAY:    prdata = {40'd0, wait_delay_r};
      mcs_pkg::REG_BURST_COUNT:   prdata = {56'd0, burst_count_r};
      mcs_pkg::REG_BURST_GAP:     prdata = {48'd0, burst_gap_r};
      mcs_pkg::REG_TIME_LIMIT:    prdata = {40'd0, time_limit_r};
      mcs_pkg::REG_RESTORE_EN:    prdata = {63'd0, restore_en_r};
      mcs_pkg::REG_CHANNEL_COUNT: prdata = {60'd0, channel_count_r};
      mcs_pkg::REG_CHANNEL_LIST:  prdata = channel_list_r;
      mcs_pkg::REG_ACTUATOR_TAB:  prdata = {48'd0, actuator_tab_r};
      default:                    prdata = 64'd0;
    endcase
  end

  // A held request is worked once the queue can take two results.
  assign rq_pop  = out_valid & out_ready;
  assign rq_room = (rq_cnt_r < 3'd3) || ((rq_cnt_r == 3'd3) && rq_pop);
  assign proc    = in_vld_r & rq_room;
  assign in_ready = ~in_vld_r | proc;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r     <= in_func;
      gate_r     <= in_gate_blocked;
      switches_r <= in_switch_states;
      found_r    <= in_channel_found;
      word_r     <= in_sample_word;
    end
  end

  // Helper values used by the request kinds.
  assign tss_inc   = mcs_pkg::sat_inc24(tss_r);
  assign tip_inc   = mcs_pkg::sat_inc24(tip_r);
  assign tsb_inc   = mcs_pkg::sat_inc24(tsb_r);
  assign act_mask  = actuator_tab_r[7:0] & ACT_LIMIT;
  assign ch_cnt    = (channel_count_r > MAX_CH) ? MAX_CH : channel_count_r;
  assign is_nan    = (word_r[30:23] == 8'hFF) && (word_r[22:0] != 23'd0);

  // Campaign logic: one pass per request.
  always_comb begin
    phase_nxt = phase_r;
    tss_nxt   = tss_r;
    tip_nxt   = tip_r;
    tsb_nxt   = tsb_r;
    burst_nxt = burst_r;
    ch_nxt    = ch_r;
    cap_nxt   = cap_r;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    ch_step   = ch_r;
    burst_inc = (burst_r == 8'hFF) ? burst_r : burst_r + 8'd1;

    case (func_r)
      mcs_pkg::FUNC_TICK: begin
        if (phase_r != mcs_pkg::PH_IDLE) begin
          tss_nxt = tss_inc;
          tip_nxt = tip_inc;
          tsb_nxt = tsb_inc;
          if (tss_inc >= time_limit_r) begin
            // Time limit reached: nothing else happens on this tick.
            phase_nxt = mcs_pkg::PH_IDLE;
            res0  = mcs_pkg::end_result(mcs_pkg::KIND_TIMEOUT, tss_inc, restore_en_r,
                                        act_mask, cap_r);
            n_res = 2'd1;
          end else if (phase_r == mcs_pkg::PH_WAIT) begin
            if (tip_inc >= wait_delay_r) begin
              phase_nxt = mcs_pkg::PH_SAMPLE;
              burst_nxt = 8'd0;
              ch_nxt    = 4'd0;
              tsb_nxt   = 24'd0;
            end
          end else if ((burst_r != 8'd0) && (tsb_inc < {8'd0, burst_gap_r})) begin
            // Still inside the gap between bursts.
            phase_nxt = phase_r;
          end else begin
            // Sample the current channel, then close the burst if it was the last.
            if (ch_r < ch_cnt) begin
              if (found_r && !is_nan) begin
                res0.kind           = mcs_pkg::KIND_SAMPLE;
                res0.sample_channel = channel_list_r[{ch_r[2:0], 3'b000} +: 8];
                res0.sample_value   = word_r;
                res0.sample_time    = tss_inc;
                res0.running        = 1'b1;
                n_res               = 2'd1;
              end
              ch_step = ch_r + 4'd1;
            end
            ch_nxt = ch_step;
            if (ch_step >= ch_cnt) begin
              ch_nxt    = 4'd0;
              burst_nxt = burst_inc;
              tsb_nxt   = 24'd0;
              if (burst_inc >= burst_count_r) begin
                phase_nxt = mcs_pkg::PH_IDLE;
                if (n_res == 2'd0) begin
                  res0 = mcs_pkg::end_result(mcs_pkg::KIND_DONE, tss_inc, restore_en_r,
                                             act_mask, cap_r);
                end else begin
                  res1 = mcs_pkg::end_result(mcs_pkg::KIND_DONE, tss_inc, restore_en_r,
                                             act_mask, cap_r);
                end
                n_res = n_res + 2'd1;
              end
            end
          end
        end
      end
      mcs_pkg::FUNC_START: begin
        n_res = 2'd1;
        if (phase_r != mcs_pkg::PH_IDLE) begin
          res0.kind    = mcs_pkg::KIND_BUSY;
          res0.running = 1'b1;
        end else if (gate_r) begin
          res0.kind    = mcs_pkg::KIND_GATE;
        end else begin
          cap_nxt   = switches_r;
          tss_nxt   = 24'd0;
          tip_nxt   = 24'd0;
          tsb_nxt   = 24'd0;
          burst_nxt = 8'd0;
          ch_nxt    = 4'd0;
          phase_nxt = (wait_delay_r == 24'd0) ? mcs_pkg::PH_SAMPLE : mcs_pkg::PH_WAIT;
          res0.kind        = mcs_pkg::KIND_STARTED;
          res0.drive_valid = 1'b1;
          res0.drive_mask  = act_mask;
          res0.drive_value = actuator_tab_r[15:8] & act_mask;
          res0.running     = 1'b1;
        end
      end
      mcs_pkg::FUNC_ABORT: begin
        if (phase_r != mcs_pkg::PH_IDLE) begin
          phase_nxt = mcs_pkg::PH_IDLE;
          res0  = mcs_pkg::end_result(mcs_pkg::KIND_ABORTED, tss_r, restore_en_r,
                                      act_mask, cap_r);
          n_res = 2'd1;
        end
      end
      default: ;
    endcase

    // Mark the final result of this request.
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // Campaign state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mcs_pkg::PH_IDLE;
      tss_r   <= 24'd0;
      tip_r   <= 24'd0;
      tsb_r   <= 24'd0;
      burst_r <= 8'd0;
      ch_r    <= 4'd0;
      cap_r   <= 8'd0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      tss_r   <= tss_nxt;
      tip_r   <= tip_nxt;
      tsb_r   <= tsb_nxt;
      burst_r <= burst_nxt;
      ch_r    <= ch_nxt;
      cap_r   <= cap_nxt;
    end
  end

  // Result queue: up to two writes and one read per cycle.
  always_ff @(posedge clk) begin
    if (proc && (n_res != 2'd0)) begin
      rq_r[rq_wr_r] <= res0;
    end
    if (proc && (n_res == 2'd2)) begin
      rq_r[rq_wr_r + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (proc) begin
        rq_wr_r <= rq_wr_r + n_res;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 2'd1;
      end
      rq_cnt_r <= rq_cnt_r + (proc ? {1'b0, n_res} : 3'd0) - {2'd0, rq_pop};
    end
  end

  // Output channel driven from the queue head.
  assign rq_head            = rq_r[rq_rd_r];
  assign out_valid          = (rq_cnt_r != 3'd0);
  assign out_kind           = rq_head.kind;
  assign out_sample_channel = rq_head.sample_channel;
  assign out_sample_value   = rq_head.sample_value;
  assign out_sample_time    = rq_head.sample_time;
  assign out_drive_valid    = rq_head.drive_valid;
  assign out_drive_mask     = rq_head.drive_mask;
  assign out_drive_value    = rq_head.drive_value;
  assign out_running        = rq_head.running;
  assign out_last           = rq_head.last;

`ifndef SYNTHESIS
  // The queue never holds more results than it has entries.
  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= 3'd4)
    else $error("result queue overflow");

  // A stalled input side always has a request waiting in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r)
    else $error("input stalled with empty input register");

  // Two results from one request are always a sample followed by done.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && n_res == 2'd2) |->
      (res0.kind == mcs_pkg::KIND_SAMPLE && res1.kind == mcs_pkg::KIND_DONE && !res0.last))
    else $error("unexpected result pair");

  // A campaign that times out or is aborted leaves the phase idle on the next cycle.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && n_res != 2'd0 && (res0.kind == mcs_pkg::KIND_TIMEOUT ||
                               res0.kind == mcs_pkg::KIND_ABORTED)) |=>
      (phase_r == mcs_pkg::PH_IDLE))
    else $error("campaign did not end");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for measurement_campaign_sequencer: directed requests,
// randomised campaigns over many register settings, and output back-pressure.
// Depends on mcs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned RANDOM_REQUESTS = 1900;
  localparam logic [1:0]  FUNC_UNUSED     = 2'd3;

  // Clock, reset and the block's ports.
  logic                        clk              = 1'b0;
  logic                        rst_n            = 1'b0;
  logic                        in_valid         = 1'b0;
  logic                        in_ready;
  logic [1:0]                  in_func          = mcs_pkg::FUNC_TICK;
  logic                        in_gate_blocked  = 1'b0;
  logic [7:0]                  in_switch_states = 8'd0;
  logic                        in_channel_found = 1'b0;
  logic [31:0]                 in_sample_word   = 32'd0;
  logic                        out_valid;
  logic                        out_ready        = 1'b0;
  logic [2:0]                  out_kind;
  logic [7:0]                  out_sample_channel;
  logic [31:0]                 out_sample_value;
  logic [23:0]                 out_sample_time;
  logic                        out_drive_valid;
  logic [7:0]                  out_drive_mask;
  logic [7:0]                  out_drive_value;
  logic                        out_running;
  logic                        out_last;
  logic                        psel             = 1'b0;
  logic                        penable          = 1'b0;
  logic                        pwrite           = 1'b0;
  logic [mcs_pkg::ADDR_W-1:0]  paddr            = '0;
  logic [mcs_pkg::DATA_W-1:0]  pwdata           = '0;
  logic [mcs_pkg::DATA_W-1:0]  cfg_rdata;
  logic                        pready;

  // Register copies as last written, starting from their reset values.
  logic [23:0] rg_wait    = 24'd0;
  logic [7:0]  rg_bursts  = 8'd1;
  logic [15:0] rg_gap     = 16'd0;
  logic [23:0] rg_limit   = 24'd60000;
  logic        rg_restore = 1'b1;
  logic [3:0]  rg_chans   = 4'd1;
  logic [63:0] rg_list    = 64'd0;
  logic [15:0] rg_act     = 16'd0;

  // Campaign state as predicted from the accepted requests.
  mcs_pkg::phase_t cs_phase       = mcs_pkg::PH_IDLE;
  logic [23:0]     cs_since_start = 24'd0;
  logic [23:0]     cs_in_phase    = 24'd0;
  logic [23:0]     cs_since_burst = 24'd0;
  logic [7:0]      cs_burst       = 8'd0;
  logic [3:0]      cs_chan        = 4'd0;
  logic [7:0]      cs_captured    = 8'd0;

  mcs_pkg::res_t pending_results[$];
  int unsigned mismatches     = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_used  = 0;
  int unsigned kinds_seen[8];
  int unsigned quiet_cycles   = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned ready_mode     = 0;
  int unsigned mode_left      = 0;

  measurement_campaign_sequencer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_gate_blocked    (in_gate_blocked),
    .in_switch_states   (in_switch_states),
    .in_channel_found   (in_channel_found),
    .in_sample_word     (in_sample_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_sample_channel (out_sample_channel),
    .out_sample_value   (out_sample_value),
    .out_sample_time    (out_sample_time),
    .out_drive_valid    (out_drive_valid),
    .out_drive_mask     (out_drive_mask),
    .out_drive_value    (out_drive_value),
    .out_running        (out_running),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (cfg_rdata),
    .pready             (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Appends one expected result to the end of the queue.
  task automatic expect_result(input mcs_pkg::res_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Ends the campaign with the given kind and the restore drive if it is enabled.
  function automatic mcs_pkg::res_t close_campaign(mcs_pkg::kind_t k);
    mcs_pkg::res_t r;
    r             = '0;
    cs_phase      = mcs_pkg::PH_IDLE;
    r.kind        = k;
    r.sample_time = cs_since_start;
    r.drive_valid = rg_restore;
    r.drive_mask  = rg_restore ? rg_act[7:0] : 8'd0;
    r.drive_value = rg_restore ? (cs_captured & rg_act[7:0]) : 8'd0;
    r.running     = 1'b0;
    return r;
  endfunction

  // Works out the results of one accepted request and queues them in order.
  task automatic predict_request(input logic [1:0] func, input logic gate,
                                 input logic [7:0] sw, input logic found,
                                 input logic [31:0] word);
    mcs_pkg::res_t r;
    int unsigned   n;
    logic [3:0]    used;
    n = 0;
    r = '0;
    case (func)
      mcs_pkg::FUNC_TICK: begin
        if (cs_phase != mcs_pkg::PH_IDLE) begin
          if (cs_since_start != mcs_pkg::MAX24) cs_since_start++;
          if (cs_in_phase != mcs_pkg::MAX24) cs_in_phase++;
          if (cs_since_burst != mcs_pkg::MAX24) cs_since_burst++;
          if (cs_since_start >= rg_limit) begin
            // A timeout ends the campaign before anything else happens.
            expect_result(close_campaign(mcs_pkg::KIND_TIMEOUT));
            n++;
          end else if (cs_phase == mcs_pkg::PH_WAIT) begin
            if (cs_in_phase >= rg_wait) begin
              cs_phase       = mcs_pkg::PH_SAMPLE;
              cs_burst       = 8'd0;
              cs_chan        = 4'd0;
              cs_since_burst = 24'd0;
            end
          end else if (cs_burst == 8'd0 || cs_since_burst >= {8'd0, rg_gap}) begin
            used = (rg_chans > 4'd8) ? 4'd8 : rg_chans;
            if (cs_chan < used) begin
              // Absent channels and NaN words are skipped silently.
              if (found && !(word[30:23] == 8'hFF && word[22:0] != 23'd0)) begin
                r.kind           = mcs_pkg::KIND_SAMPLE;
                r.sample_channel = rg_list[{cs_chan[2:0], 3'b000} +: 8];
                r.sample_value   = word;
                r.sample_time    = cs_since_start;
                r.running        = 1'b1;
                expect_result(r);
                n++;
              end
              cs_chan++;
            end
            if (cs_chan >= used) begin
              cs_chan = 4'd0;
              if (cs_burst != 8'hFF) cs_burst++;
              cs_since_burst = 24'd0;
              if (cs_burst >= rg_bursts) begin
                expect_result(close_campaign(mcs_pkg::KIND_DONE));
                n++;
              end
            end
          end
        end
      end
      mcs_pkg::FUNC_START: begin
        if (cs_phase != mcs_pkg::PH_IDLE) begin
          r.kind    = mcs_pkg::KIND_BUSY;
          r.running = 1'b1;
        end else if (gate) begin
          r.kind = mcs_pkg::KIND_GATE;
        end else begin
          cs_captured    = sw;
          cs_since_start = 24'd0;
          cs_in_phase    = 24'd0;
          cs_since_burst = 24'd0;
          cs_burst       = 8'd0;
          cs_chan        = 4'd0;
          cs_phase       = (rg_wait == 24'd0) ? mcs_pkg::PH_SAMPLE : mcs_pkg::PH_WAIT;
          r.kind         = mcs_pkg::KIND_STARTED;
          r.drive_valid  = 1'b1;
          r.drive_mask   = rg_act[7:0];
          r.drive_value  = rg_act[15:8] & rg_act[7:0];
          r.running      = 1'b1;
        end
        expect_result(r);
        n = 1;
      end
      mcs_pkg::FUNC_ABORT: begin
        if (cs_phase != mcs_pkg::PH_IDLE) begin
          expect_result(close_campaign(mcs_pkg::KIND_ABORTED));
          n = 1;
        end
      end
      default: ;
    endcase
    if (n != 0) pending_results[pending_results.size() - 1].last = 1'b1;
  endtask

  // Offers one request and holds it until the block accepts it.
  task automatic offer_request(input logic [1:0] func, input logic gate,
                               input logic [7:0] sw, input logic found,
                               input logic [31:0] word);
    bit taken;
    in_valid         <= 1'b1;
    in_func          <= func;
    in_gate_blocked  <= gate;
    in_switch_states <= sw;
    in_channel_found <= found;
    in_sample_word   <= word;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    predict_request(func, gate, sw, found, word);
    requests_sent++;
  endtask

  // Leaves the request channel empty for a number of cycles.
  task automatic hold_off(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending until every expected result has arrived and the block is quiet.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access until pready.
  task automatic write_register(input mcs_pkg::reg_idx_t idx, input logic [63:0] value);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    case (idx)
      mcs_pkg::REG_WAIT_DELAY:    rg_wait    = value[23:0];
      mcs_pkg::REG_BURST_COUNT:   rg_bursts  = value[7:0];
      mcs_pkg::REG_BURST_GAP:     rg_gap     = value[15:0];
      mcs_pkg::REG_TIME_LIMIT:    rg_limit   = value[23:0];
      mcs_pkg::REG_RESTORE_EN:    rg_restore = value[0];
      mcs_pkg::REG_CHANNEL_COUNT: rg_chans   = value[3:0];
      mcs_pkg::REG_CHANNEL_LIST:  rg_list    = value;
      mcs_pkg::REG_ACTUATOR_TAB:  rg_act     = value[15:0];
      default: ;
    endcase
  endtask

  // Ends any running campaign, lets the block go quiet, then writes every register.
  task automatic apply_settings(input logic [23:0] delay, input logic [7:0] bursts,
                                input logic [15:0] gap, input logic [23:0] limit,
                                input logic restore, input logic [3:0] chans,
                                input logic [63:0] codes, input logic [15:0] act);
    if (cs_phase != mcs_pkg::PH_IDLE) begin
      offer_request(mcs_pkg::FUNC_ABORT, 1'b0, 8'd0, 1'b0, 32'd0);
    end
    wait_drain();
    write_register(mcs_pkg::REG_WAIT_DELAY, {40'd0, delay});
    write_register(mcs_pkg::REG_BURST_COUNT, {56'd0, bursts});
    write_register(mcs_pkg::REG_BURST_GAP, {48'd0, gap});
    write_register(mcs_pkg::REG_TIME_LIMIT, {40'd0, limit});
    write_register(mcs_pkg::REG_RESTORE_EN, {63'd0, restore});
    write_register(mcs_pkg::REG_CHANNEL_COUNT, {60'd0, chans});
    write_register(mcs_pkg::REG_CHANNEL_LIST, codes);
    write_register(mcs_pkg::REG_ACTUATOR_TAB, {48'd0, act});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Idle requests, refusals, both drive kinds, skipped samples, gaps,
  // a tick with a sample and a done, abort and timeout.
  task automatic test_directed_cases();
    apply_settings(24'd2, 8'd2, 16'd3, 24'd40, 1'b1, 4'd3,
                   64'hC3A5_5A3C_00FF_8000, 16'hA53C);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'h00, 1'b1, 32'h3F80_0000);
    offer_request(mcs_pkg::FUNC_ABORT, 1'b1, 8'hFF, 1'b0, 32'hFFFF_FFFF);
    offer_request(FUNC_UNUSED, 1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    offer_request(mcs_pkg::FUNC_START, 1'b1, 8'h00, 1'b0, 32'd0);
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'hFF, 1'b0, 32'd0);
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'h0F, 1'b1, 32'd0);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h1234_5678);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h1234_5678);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h0000_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b0, 32'h3F80_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h7FC0_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h4000_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h4000_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h7F80_0000);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'hFFFF_FFFF);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h8000_0000);
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'h00, 1'b0, 32'd0);
    offer_request(mcs_pkg::FUNC_ABORT, 1'b0, 8'h00, 1'b0, 32'd0);
    // Time limit of one tick, no restore.
    apply_settings(24'd0, 8'd1, 16'd0, 24'd1, 1'b0, 4'd1, 64'h0000_0000_0000_00FF, 16'h00FF);
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'hA5, 1'b0, 32'd0);
    offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, 32'h7F80_0001);
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'h5A, 1'b0, 32'd0);
    offer_request(mcs_pkg::FUNC_ABORT, 1'b0, 8'h00, 1'b0, 32'd0);
  endtask

  // Random campaigns under a series of register settings, extremes first.
  task automatic test_register_settings();
    int unsigned setting;
    int unsigned budget;
    int unsigned counted;
    int unsigned burst_left;
    int unsigned roll;
    int unsigned pick;
    bit          steady;
    logic [1:0]  func;
    logic [31:0] word;
    counted    = 0;
    burst_left = 0;
    setting    = 0;
    while (counted < RANDOM_REQUESTS) begin
      case (setting)
        0: apply_settings(24'd0, 8'd0, 16'd0, 24'd0, 1'b0, 4'd0, 64'd0, 16'h0000);
        1: apply_settings(mcs_pkg::MAX24, 8'hFF, 16'hFFFF, mcs_pkg::MAX24, 1'b1, 4'hF,
                          '1, 16'hFFFF);
        2: apply_settings(24'd0, 8'hFF, 16'd0, mcs_pkg::MAX24, 1'b1, 4'd1,
                          {$urandom, $urandom}, 16'($urandom));
        default: apply_settings(24'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                                16'($urandom_range(0, 6)),
                                ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 30))
                                                            : 24'($urandom_range(40, 400)),
                                1'($urandom_range(0, 1)),
                                ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(1, 8)),
                                {$urandom, $urandom}, 16'($urandom));
      endcase
      budget = (setting == 2) ? 320 : $urandom_range(60, 120);
      // Every fifth setting runs without the random idle gaps between bursts.
      steady = (setting % 5 == 4);
      repeat (budget) begin
        if (burst_left == 0) begin
          if (!steady) hold_off($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        if ($urandom_range(0, 59) == 0) wait_drain();
        // Mostly well-formed campaigns: starts while idle, ticks while running.
        roll = $urandom_range(0, 99);
        if (roll < 2) func = FUNC_UNUSED;
        else if (cs_phase == mcs_pkg::PH_IDLE) func = (roll < 70) ? mcs_pkg::FUNC_START :
                                                      (roll < 85) ? mcs_pkg::FUNC_TICK :
                                                                    mcs_pkg::FUNC_ABORT;
        else func = (roll < 4) ? mcs_pkg::FUNC_ABORT :
                    (roll < 8) ? mcs_pkg::FUNC_START : mcs_pkg::FUNC_TICK;
        pick = $urandom_range(0, 9);
        word = $urandom;
        if (pick == 0) begin
          word[30:23] = 8'hFF;
          if (word[22:0] == 23'd0) word[0] = 1'b1;
        end else if (pick == 1) begin
          word[30:0] = {8'hFF, 23'd0};
        end else if (pick == 2) begin
          word[30:0] = 31'd0;
        end
        if (func != FUNC_UNUSED &&
            (cs_phase != mcs_pkg::PH_IDLE || func == mcs_pkg::FUNC_START)) counted++;
        offer_request(func, $urandom_range(0, 7) == 0, 8'($urandom),
                      $urandom_range(0, 7) != 0, word);
      end
      setting++;
    end
  endtask

  // The receiver holds off for a long stretch while samples keep being requested.
  task automatic test_backpressure();
    apply_settings(24'd0, 8'd20, 16'd0, mcs_pkg::MAX24, 1'b1, 4'd8, {$urandom, $urandom},
                   16'($urandom));
    offer_request(mcs_pkg::FUNC_START, 1'b0, 8'($urandom), 1'b0, 32'd0);
    hold_request = HOLD_CYCLES;
    repeat (40) begin
      offer_request(mcs_pkg::FUNC_TICK, 1'b0, 8'd0, 1'b1, $urandom & 32'hBFFF_FFFF);
    end
    offer_request(mcs_pkg::FUNC_ABORT, 1'b0, 8'd0, 1'b0, 32'd0);
  endtask

  // Receiver: a long hold when asked for, otherwise a changing stall pattern.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_request != 0) begin
      out_ready    <= 1'b0;
      hold_left    = hold_request - 1;
      hold_request = 0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 200);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Reports one differing field of a result.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: result %0d %s expected 0x%0h, got 0x%0h",
               $time, results_seen, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker: outputs are stable at the falling edge before the accepting edge.
  always @(negedge clk) begin
    mcs_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d time %0d",
                 $time, out_kind, out_sample_time);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("sample_channel", 32'(want.sample_channel), 32'(out_sample_channel));
        check_field("sample_value", want.sample_value, out_sample_value);
        check_field("sample_time", 32'(want.sample_time), 32'(out_sample_time));
        check_field("drive_valid", 32'(want.drive_valid), 32'(out_drive_valid));
        check_field("drive_mask", 32'(want.drive_mask), 32'(out_drive_mask));
        check_field("drive_value", 32'(want.drive_value), 32'(out_drive_value));
        check_field("running", 32'(want.running), 32'(out_running));
        check_field("last", 32'(want.last), 32'(out_last));
      end
      kinds_seen[out_kind]++;
      results_seen++;
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(negedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles++;
    end else begin
      $display("%0t: nothing accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_settings();
    test_backpressure();
    wait_drain();
    $display("Covered %0d requests over %0d register settings, %0d results checked:",
             requests_sent, settings_used, results_seen);
    $display("  %0d started, %0d refused, %0d samples, %0d done, %0d aborted, %0d timed out",
             kinds_seen[mcs_pkg::KIND_STARTED],
             kinds_seen[mcs_pkg::KIND_BUSY] + kinds_seen[mcs_pkg::KIND_GATE],
             kinds_seen[mcs_pkg::KIND_SAMPLE], kinds_seen[mcs_pkg::KIND_DONE],
             kinds_seen[mcs_pkg::KIND_ABORTED], kinds_seen[mcs_pkg::KIND_TIMEOUT]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
